// File: rtl/core/line_pixel_generator_assert.svh
// assertion macros for the line pixel generator
// no dependencies; included by lpg_ctrl, which checks its own control logic
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LPG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lpg_pkg.sv
// shared types and constants for the line pixel generator
// no dependencies; imported by every module of the block
package lpg_pkg;

    localparam int COORD_W        = 6;
    localparam int SHADE_W        = 8;
    localparam int COORD_BITS_DEF = 6;
    localparam logic [SHADE_W-1:0] SHADE_RESET = 8'hFF;

    typedef struct packed {
        logic load;
        logic step;
    } lpg_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic last;
    } lpg_status_t;

endpackage

// File: rtl/core/lpg_ctrl.sv
// controller for the line pixel generator: segment accept and pixel emission sequencing
// depends on lpg_pkg and line_pixel_generator_assert.svh
`include "line_pixel_generator_assert.svh"

module lpg_ctrl
    import lpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  lpg_status_t status,
    output lpg_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_valid && !in_stall;
    assign cmd.step  = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && !status.zero_len)
                begin
                    state_next     = ST_EMIT;
                    out_valid_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (cmd.step && status.last)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LPG_ASSERT_IMP(a_no_accept_while_emit, clk, rst_n, out_valid_reg, in_stall, "segment accepted while pixels pending")
    `LPG_ASSERT_NXT(a_start_emit, clk, rst_n, cmd.load && !status.zero_len, out_valid_reg, "nonempty segment produced no pixel")
    `LPG_ASSERT_NXT(a_last_ends, clk, rst_n, cmd.step && status.last, !out_valid_reg && !in_stall, "pixels continued past last")

endmodule

// File: rtl/core/lpg_dp.sv
// datapath for the line pixel generator: segment setup, error accumulator and pixel registers
// depends on lpg_pkg
module lpg_dp
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SHADE_W-1:0] cfg_wdata,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  lpg_cmd_t           cmd,
    output lpg_status_t        status,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic [SHADE_W-1:0] pixel_shade,
    output logic               last_pixel
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] sx, sy, ex, ey;
    logic [CB-1:0] dx, dy;
    logic          xmaj;
    logic [CB-1:0] a0, a1, b0, b1;
    logic [CB-1:0] dmaj_in, dmin_in;

    logic [SHADE_W-1:0] shade_reg;
    logic               xmaj_reg;
    logic [CB-1:0]      a_reg, a_next;
    logic [CB-1:0]      b_reg, b_next;
    logic [CB-1:0]      btgt_reg;
    logic [CB-1:0]      dmaj_reg;
    logic [CB-1:0]      dmin_reg;
    logic [CB-1:0]      err_reg, err_next;
    logic [CB-1:0]      cnt_reg;

    logic [CB+1:0] err_sum;
    logic [CB+1:0] err_lim;

    assign sx = start_x[CB-1:0];
    assign sy = start_y[CB-1:0];
    assign ex = end_x[CB-1:0];
    assign ey = end_y[CB-1:0];

    assign dx      = (sx >= ex) ? (sx - ex) : (ex - sx);
    assign dy      = (sy >= ey) ? (sy - ey) : (ey - sy);
    assign xmaj    = (dx >= dy);
    assign a0      = xmaj ? sx : sy;
    assign a1      = xmaj ? ex : ey;
    assign b0      = xmaj ? sy : sx;
    assign b1      = xmaj ? ey : ex;
    assign dmaj_in = xmaj ? dx : dy;
    assign dmin_in = xmaj ? dy : dx;

    assign status.zero_len = (dmaj_in == '0);
    assign status.last     = (cnt_reg == CB'(1));

    // error step toward the next pixel
    assign err_sum = (CB+2)'(err_reg) + (CB+2)'(dmin_reg) + (CB+2)'(1);
    assign err_lim = (CB+2)'(dmaj_reg) + (CB+2)'(1);

    always_comb
    begin
        a_next   = a_reg + CB'(1);
        b_next   = b_reg;
        err_next = err_sum[CB-1:0];
        if (err_sum >= err_lim)
        begin
            err_next = CB'(err_sum - err_lim);
            if (btgt_reg > b_reg)
                b_next = b_reg + CB'(1);
            else if (btgt_reg < b_reg)
                b_next = b_reg - CB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shade_reg <= SHADE_RESET;
        else if (cfg_we)
            shade_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xmaj_reg <= xmaj;
            dmaj_reg <= dmaj_in;
            dmin_reg <= dmin_in;
            err_reg  <= '0;
            cnt_reg  <= dmaj_in;
            if (a0 < a1)
            begin
                a_reg    <= a0;
                b_reg    <= b0;
                btgt_reg <= b1;
            end
            else
            begin
                a_reg    <= a1;
                b_reg    <= b1;
                btgt_reg <= b0;
            end
        end
        else if (cmd.step)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            err_reg <= err_next;
            cnt_reg <= cnt_reg - CB'(1);
        end
    end

    assign pixel_x     = COORD_W'(xmaj_reg ? a_reg : b_reg);
    assign pixel_y     = COORD_W'(xmaj_reg ? b_reg : a_reg);
    assign pixel_shade = shade_reg;
    assign last_pixel  = status.last;

endmodule

// File: rtl/core/line_pixel_generator.sv
// line pixel generator: one segment in, one pixel transfer per cycle while the walk runs and
// out_stall is low; the first pixel is valid in the cycle after the segment transfer
// a segment has n pixels (n = major delta, up to 63); no new segment is taken until the
// last pixel has been transferred, and a degenerate segment emits nothing
// reset: asynchronous active low; controller goes idle, shade register returns to 255
module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SHADE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic [SHADE_W-1:0] pixel_shade,
    output logic               last_pixel
);

    lpg_cmd_t    cmd;
    lpg_status_t status;

    lpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lpg_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .cmd         (cmd),
        .status      (status),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_shade (pixel_shade),
        .last_pixel  (last_pixel)
    );

endmodule

// File: tb/line_pixel_checker.sv
// pixel checker for the line pixel generator: watches the segment, pixel and shade ports,
// predicts the pixel walk of every accepted segment and compares each pixel transfer
// depends on lpg_pkg; instantiated beside the block by line_pixel_generator_tb
module line_pixel_checker
    import lpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SHADE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic [SHADE_W-1:0] pixel_shade,
    input  logic               last_pixel,
    output int                 outstanding,
    output int                 fail_count
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SHADE_W-1:0] shade;
        logic               last;
    } pixel_t;

    pixel_t             expected_pixels[$];
    logic [SHADE_W-1:0] line_shade;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic trace_segment(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                 input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        int     x0, y0, x1, y1, adx, ady;
        int     a0, a1, b0, b1;
        int     walk_from, walk_len, minor, minor_to, dmin, err;
        bit     x_major;
        pixel_t pix;
        x0 = int'(sx);
        y0 = int'(sy);
        x1 = int'(ex);
        y1 = int'(ey);
        adx = (x0 >= x1) ? x0 - x1 : x1 - x0;
        ady = (y0 >= y1) ? y0 - y1 : y1 - y0;
        x_major = (adx >= ady);
        a0 = x_major ? x0 : y0;
        a1 = x_major ? x1 : y1;
        b0 = x_major ? y0 : x0;
        b1 = x_major ? y1 : x1;
        if (a0 < a1)
        begin
            walk_from = a0;
            walk_len  = a1 - a0;
            minor     = b0;
            minor_to  = b1;
        end
        else
        begin
            walk_from = a1;
            walk_len  = a0 - a1;
            minor     = b1;
            minor_to  = b0;
        end
        dmin = (b0 >= b1) ? b0 - b1 : b1 - b0;
        err = 0;
        for (int k = 0; k < walk_len; k++)
        begin
            pix.x     = COORD_W'(x_major ? walk_from + k : minor);
            pix.y     = COORD_W'(x_major ? minor : walk_from + k);
            pix.shade = line_shade;
            pix.last  = (k == walk_len - 1);
            expected_pixels.push_back(pix);
            err += dmin + 1;
            if (err >= walk_len + 1)
            begin
                err -= walk_len + 1;
                if (minor_to > minor)
                    minor++;
                else if (minor_to < minor)
                    minor--;
            end
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x, pixel_y));
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (pixel_x !== want.x)
                report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, want.x));
            if (pixel_y !== want.y)
                report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, want.y));
            if (pixel_shade !== want.shade)
                report_mismatch($sformatf("pixel_shade %0d, want %0d", pixel_shade, want.shade));
            if (last_pixel !== want.last)
                report_mismatch($sformatf("last_pixel %0b, want %0b", last_pixel, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            line_shade  = SHADE_RESET;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                line_shade = cfg_wdata;
            if (in_valid && !in_stall)
                trace_segment(start_x, start_y, end_x, end_y);
            if (out_valid && !out_stall)
                check_pixel();
            outstanding <= expected_pixels.size();
        end
    end

endmodule

// File: tb/line_pixel_generator_tb.sv
// top of the line pixel generator testbench: clock, reset, segment and shade stimulus,
// receiver stalls, watchdog and verdict
// depends on lpg_pkg, line_pixel_generator and line_pixel_checker
module line_pixel_generator_tb;
    import lpg_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_SEGS = 150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SHADE_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [COORD_W-1:0] start_x = '0;
    logic [COORD_W-1:0] start_y = '0;
    logic [COORD_W-1:0] end_x = '0;
    logic [COORD_W-1:0] end_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [SHADE_W-1:0] pixel_shade;
    logic               last_pixel;
    logic               hold_off = 1'b0;
    int                 outstanding;
    int                 fail_count;
    int                 quiet_cycles = 0;
    int                 send_idle_pct = 28;
    int                 recv_idle_pct = 72;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    line_pixel_generator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_shade(pixel_shade),
        .last_pixel (last_pixel)
    );

    line_pixel_checker u_pixel_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_shade(pixel_shade),
        .last_pixel (last_pixel),
        .outstanding(outstanding),
        .fail_count (fail_count)
    );

    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("line_pixel_generator regression: fail");
            $finish;
        end
    end

    task automatic send_segment(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        // a degenerate segment may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_shade(input logic [SHADE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_segments(input int count);
        logic [COORD_W-1:0] sx, sy, ex, ey;
        int                 kind;
        repeat (count)
        begin
            kind = $urandom_range(99);
            sx = COORD_W'($urandom);
            sy = COORD_W'($urandom);
            ex = COORD_W'($urandom);
            ey = COORD_W'($urandom);
            if (kind >= 55 && kind < 85)
            begin
                ex = COORD_W'(sx + $urandom_range(16) - 8);
                ey = COORD_W'(sy + $urandom_range(16) - 8);
            end
            else if (kind >= 85 && kind < 91)
            begin
                ex = sx;
                ey = sy;
            end
            else if (kind >= 91 && kind < 96)
            begin
                ey = sy;
            end
            else if (kind >= 96)
            begin
                ex = sx;
            end
            send_segment(sx, sy, ex, ey);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed segments at the reset shade
        send_segment(6'd0, 6'd0, 6'd63, 6'd0);
        send_segment(6'd63, 6'd63, 6'd0, 6'd0);
        send_segment(6'd0, 6'd0, 6'd0, 6'd63);
        send_segment(6'd0, 6'd63, 6'd63, 6'd0);
        send_segment(6'd63, 6'd0, 6'd0, 6'd63);
        send_segment(6'd5, 6'd5, 6'd5, 6'd5);
        send_segment(6'd63, 6'd63, 6'd63, 6'd63);
        send_segment(6'd0, 6'd0, 6'd0, 6'd0);
        send_segment(6'd3, 6'd7, 6'd40, 6'd7);
        send_segment(6'd7, 6'd50, 6'd7, 6'd3);
        send_segment(6'd0, 6'd0, 6'd63, 6'd62);
        send_segment(6'd62, 6'd0, 6'd0, 6'd63);
        send_segment(6'd20, 6'd30, 6'd21, 6'd50);
        send_segment(6'd63, 6'd63, 6'd63, 6'd0);
        send_segment(6'd0, 6'd0, 6'd1, 6'd0);
        send_segment(6'd0, 6'd0, 6'd0, 6'd1);
        send_segment(6'd1, 6'd1, 6'd0, 6'd0);
        send_segment(6'd42, 6'd21, 6'd21, 6'd42);
        send_segment(6'd10, 6'd60, 6'd50, 6'd59);
        send_segment(6'd33, 6'd12, 6'd2, 6'd17);

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            if (phase == 0)
            begin
                write_shade(8'h00);
                // long receiver hold-off while segments keep coming
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                    send_random_segments(RANDOM_SEGS);
                join
            end
            else
            begin
                send_idle_pct = (phase == 1) ? 72 : 0;
                recv_idle_pct = (phase == 1) ? 28 : 0;
                write_shade((phase == 1) ? SHADE_W'($urandom_range(1, 254)) : 8'hFF);
                send_random_segments(RANDOM_SEGS);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("line_pixel_generator regression: pass");
        else
            $display("line_pixel_generator regression: fail");
        $finish;
    end

endmodule
